// ===== sv/tsmrd_pkg.sv =====
// Shared types, widths and codes for the trigger state decoder.
`default_nettype none

package tsmrd_pkg;

  // Capacity and channel limits
  localparam int STATE_LIMIT   = 1024;
  localparam int CHANNEL_LIMIT = 16;

  // Field widths
  localparam int ID_W      = 10;  // state number / decoded index width
  localparam int CH_W      = 6;
  localparam int MODE_W    = 2;
  localparam int CNT_W     = 11;  // frequency / waveform count, divider remainder
  localparam int P1_W      = CH_W + 1;
  localparam int P2_W      = 2 * CNT_W;
  localparam int TOT_W     = P1_W + P2_W;
  localparam int OUT_TOT_W = 11;
  localparam int STAT_W    = 3;

  // APB port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int IDX_LO = 2;
  localparam int IDX_W  = 3;

  // Pipeline shape
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = ID_W / BITS_PER_STAGE;
  localparam int CHECK_STAGES   = 3;
  localparam int PIPE_LAT       = CHECK_STAGES + 2 * DIV_STAGES + 1;

  localparam logic [MODE_W-1:0] POL_BOTH = 2'd2;
  localparam logic [MODE_W-1:0] POL_BAD  = 2'd3;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_CFG   = 3'd1,
    ST_BAD_PARAM = 3'd2,
    ST_CAPACITY  = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  typedef enum logic [IDX_W-1:0] {
    REG_MAP_EN     = 3'd0,
    REG_CH_COUNT   = 3'd1,
    REG_POL_MODE   = 3'd2,
    REG_FREQ_COUNT = 3'd3,
    REG_WAVE_COUNT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic              map_en;
    logic [CH_W-1:0]   ch;
    logic [MODE_W-1:0] mode;
    logic [CNT_W-1:0]  freq;
    logic [CNT_W-1:0]  wave;
  } cfg_t;

  // Sideband carried through the divider stages
  typedef struct packed {
    status_t              status;
    logic [OUT_TOT_W-1:0] total;
    logic [ID_W-1:0]      wave;
  } side_t;

endpackage

`default_nettype wire

// ===== sv/tsmrd_check.sv =====
// Configuration check, state total and range check over three register stages.
`default_nettype none

module tsmrd_check import tsmrd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [ID_W-1:0]      in_id,
  input  cfg_t                 cfg,
  output logic                 out_valid,
  output logic [ID_W-1:0]      out_id,
  output status_t              out_status,
  output logic [OUT_TOT_W-1:0] out_total
);

  // stage a: parameter check, partial products
  logic              va;
  logic [ID_W-1:0]   id_a;
  status_t           st_a;
  logic [P1_W-1:0]   p1_a;
  logic [P2_W-1:0]   p2_a;
  // stage b: full total
  logic              vb;
  logic [ID_W-1:0]   id_b;
  status_t           st_b;
  logic [TOT_W-1:0]  tot_b;

  status_t st_a_next;
  status_t st_c_next;
  logic    bad_param;

  always_comb begin
    bad_param = (cfg.ch == '0) || (cfg.ch > CH_W'(CHANNEL_LIMIT)) ||
                (cfg.mode == POL_BAD) || (cfg.freq == '0) || (cfg.wave == '0);
    if (!cfg.map_en) begin
      st_a_next = ST_NOT_CFG;
    end else if (bad_param) begin
      st_a_next = ST_BAD_PARAM;
    end else begin
      st_a_next = ST_OK;
    end
  end

  always_comb begin
    if (st_b != ST_OK) begin
      st_c_next = st_b;
    end else if (tot_b > TOT_W'(STATE_LIMIT)) begin
      st_c_next = ST_CAPACITY;
    end else if ({{(TOT_W-ID_W){1'b0}}, id_b} >= tot_b) begin
      st_c_next = ST_RANGE;
    end else begin
      st_c_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      va        <= in_valid;
      vb        <= va;
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    id_a <= in_id;
    st_a <= st_a_next;
    p1_a <= (cfg.mode == POL_BOTH) ? {cfg.ch, 1'b0} : {1'b0, cfg.ch};
    p2_a <= cfg.freq * cfg.wave;

    id_b  <= id_a;
    st_b  <= st_a;
    tot_b <= p1_a * p2_a;

    out_id     <= id_b;
    out_status <= st_c_next;
    // only an ok or out-of-range item reports its total
    out_total  <= (st_c_next == ST_OK || st_c_next == ST_RANGE) ?
                  tot_b[OUT_TOT_W-1:0] : '0;
  end

endmodule

`default_nettype wire

// ===== sv/tsmrd_div_stage.sv =====
// One registered stage of a restoring divider, two quotient bits per stage.
`default_nettype none

module tsmrd_div_stage import tsmrd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [CNT_W-1:0] divisor,
  input  logic [CNT_W-1:0] in_rem,
  input  logic [ID_W-1:0]  in_dq,
  input  side_t            in_side,
  output logic             out_valid,
  output logic [CNT_W-1:0] out_rem,
  output logic [ID_W-1:0]  out_dq,
  output side_t            out_side
);

  // dq: remaining dividend bits on top, quotient bits shifted in below
  logic [CNT_W-1:0] rem_w;
  logic [ID_W-1:0]  dq_w;
  logic [CNT_W-1:0] trial;

  always_comb begin
    rem_w = in_rem;
    dq_w  = in_dq;
    trial = '0;
    for (int i = 0; i < BITS_PER_STAGE; i++) begin
      // partial remainder never exceeds the 10-bit dividend, top bit is free
      trial = {rem_w[CNT_W-2:0], dq_w[ID_W-1]};
      dq_w  = {dq_w[ID_W-2:0], 1'b0};
      if (trial >= divisor) begin
        rem_w   = trial - divisor;
        dq_w[0] = 1'b1;
      end else begin
        rem_w = trial;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_rem  <= rem_w;
    out_dq   <= dq_w;
    out_side <= in_side;
  end

endmodule

`default_nettype wire

// ===== sv/trigger_state_mixed_radix_decode.sv =====
// Top level of the trigger state decoder: APB registers, check stages, divider pipeline.
`default_nettype none

// Pipeline: done rises once the start transaction has passed 3 check stages,
//   10 divider stages at two quotient bits each and 1 output register.
// Throughput: one transaction per cycle; busy is never raised, and the result
//   side cannot stall, so every transaction leaves exactly one result strobe.
// Reset (rst, synchronous): clears all configuration registers and every
//   pipeline valid bit; items in flight are dropped.
module trigger_state_mixed_radix_decode import tsmrd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // item transaction
  input  logic                 start,
  output logic                 busy,
  input  logic [ID_W-1:0]      state_number,
  // result transaction
  output logic                 done,
  output logic [STAT_W-1:0]    status,
  output logic [CH_W-1:0]      switch_channel,
  output logic                 second_switch_select,
  output logic                 polarity,
  output logic [ID_W-1:0]      frequency_index,
  output logic [ID_W-1:0]      waveform_index,
  output logic [OUT_TOT_W-1:0] state_total,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]    prdata,
  output logic                 pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers. The user must write them only with the pipeline
  // empty (the block does not enforce it), so every stage may read these directly.
  // ---------------------------------------------------------------------------
  cfg_t     cfg;
  reg_idx_t reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[IDX_LO +: IDX_W]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_MAP_EN:     cfg.map_en <= pwdata[0];
        REG_CH_COUNT:   cfg.ch     <= pwdata[CH_W-1:0];
        REG_POL_MODE:   cfg.mode   <= pwdata[MODE_W-1:0];
        REG_FREQ_COUNT: cfg.freq   <= pwdata[CNT_W-1:0];
        REG_WAVE_COUNT: cfg.wave   <= pwdata[CNT_W-1:0];
        default: ;  // addresses past the register list are ignored
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MAP_EN:     prdata = {{(DATA_W-1){1'b0}}, cfg.map_en};
      REG_CH_COUNT:   prdata = {{(DATA_W-CH_W){1'b0}}, cfg.ch};
      REG_POL_MODE:   prdata = {{(DATA_W-MODE_W){1'b0}}, cfg.mode};
      REG_FREQ_COUNT: prdata = {{(DATA_W-CNT_W){1'b0}}, cfg.freq};
      REG_WAVE_COUNT: prdata = {{(DATA_W-CNT_W){1'b0}}, cfg.wave};
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Front end: status and state total. The pipeline never holds off input.
  // ---------------------------------------------------------------------------
  logic                 acc;
  logic                 chk_valid;
  logic [ID_W-1:0]      chk_id;
  status_t              chk_status;
  logic [OUT_TOT_W-1:0] chk_total;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  tsmrd_check u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (acc),
    .in_id      (state_number),
    .cfg        (cfg),
    .out_valid  (chk_valid),
    .out_id     (chk_id),
    .out_status (chk_status),
    .out_total  (chk_total)
  );

  // ---------------------------------------------------------------------------
  // Divider chain. First DIV_STAGES stages: id / waveform_count, remainder is
  // the waveform index. Next DIV_STAGES: quotient / frequency_count, remainder
  // is the frequency index, quotient holds polarity and channel digits.
  // On a bad configuration the divisor may be zero; the result is zeroed later.
  // ---------------------------------------------------------------------------
  localparam int NSTG = 2 * DIV_STAGES;

  logic             si_valid [NSTG];
  logic [CNT_W-1:0] si_rem   [NSTG];
  logic [ID_W-1:0]  si_dq    [NSTG];
  side_t            si_side  [NSTG];
  logic             so_valid [NSTG];
  logic [CNT_W-1:0] so_rem   [NSTG];
  logic [ID_W-1:0]  so_dq    [NSTG];
  side_t            so_side  [NSTG];

  for (genvar j = 0; j < NSTG; j++) begin : g_div
    if (j == 0) begin : g_first
      assign si_valid[j] = chk_valid;
      assign si_rem[j]   = '0;
      assign si_dq[j]    = chk_id;
      assign si_side[j]  = '{status: chk_status, total: chk_total, wave: '0};
    end else if (j == DIV_STAGES) begin : g_hand
      // waveform digit done: keep remainder, divide the quotient again
      assign si_valid[j] = so_valid[j-1];
      assign si_rem[j]   = '0;
      assign si_dq[j]    = so_dq[j-1];
      assign si_side[j]  = '{status: so_side[j-1].status,
                             total:  so_side[j-1].total,
                             wave:   so_rem[j-1][ID_W-1:0]};
    end else begin : g_mid
      assign si_valid[j] = so_valid[j-1];
      assign si_rem[j]   = so_rem[j-1];
      assign si_dq[j]    = so_dq[j-1];
      assign si_side[j]  = so_side[j-1];
    end

    tsmrd_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (si_valid[j]),
      .divisor   ((j < DIV_STAGES) ? cfg.wave : cfg.freq),
      .in_rem    (si_rem[j]),
      .in_dq     (si_dq[j]),
      .in_side   (si_side[j]),
      .out_valid (so_valid[j]),
      .out_rem   (so_rem[j]),
      .out_dq    (so_dq[j]),
      .out_side  (so_side[j])
    );
  end

  // ---------------------------------------------------------------------------
  // Output stage: in both-polarity mode split polarity off the last quotient,
  // channel counts from 1, zero every decoded field unless status is ok.
  // ---------------------------------------------------------------------------
  logic [ID_W-1:0] q_last;
  side_t           side_last;
  logic            ok_last;
  logic [ID_W:0]   chan_full;
  logic            pol_dec;

  assign q_last    = so_dq[NSTG-1];
  assign side_last = so_side[NSTG-1];
  assign ok_last   = (side_last.status == ST_OK);

  always_comb begin
    if (cfg.mode == POL_BOTH) begin
      pol_dec   = q_last[0];
      chan_full = {2'b00, q_last[ID_W-1:1]} + (ID_W+1)'(1);
    end else begin
      pol_dec   = cfg.mode[0];
      chan_full = {1'b0, q_last} + (ID_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= so_valid[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    status               <= side_last.status;
    state_total          <= side_last.total;
    switch_channel       <= ok_last ? chan_full[CH_W-1:0] : '0;
    polarity             <= ok_last && pol_dec;
    second_switch_select <= ok_last && pol_dec;
    frequency_index      <= ok_last ? so_rem[NSTG-1][ID_W-1:0] : '0;
    waveform_index       <= ok_last ? side_last.wave : '0;
  end

endmodule

`default_nettype wire

// ===== sv/tsmrd_checker.sv =====
// Port-level assertions for the trigger state decoder, bound to the top level.
`default_nettype none

module tsmrd_checker import tsmrd_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 done,
  input logic [STAT_W-1:0]    status,
  input logic [CH_W-1:0]      switch_channel,
  input logic                 second_switch_select,
  input logic                 polarity,
  input logic [ID_W-1:0]      frequency_index,
  input logic [ID_W-1:0]      waveform_index,
  input logic [OUT_TOT_W-1:0] state_total
);

  // every accepted transaction yields a result after the fixed latency
  a_lat: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_LAT done)
    else $error("result missing after accepted transaction");

  // no result strobe without a matching accepted transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LAT))
    else $error("result strobe without matching transaction");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |->
      (switch_channel == '0 && !polarity && !second_switch_select &&
       frequency_index == '0 && waveform_index == '0))
    else $error("decoded fields not cleared on error status");

  a_ok_fields: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_OK) |->
      (switch_channel != '0 && second_switch_select == polarity &&
       {1'b0, waveform_index} < state_total && {1'b0, frequency_index} < state_total))
    else $error("inconsistent decode on ok status");

  a_err_total: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_NOT_CFG || status == ST_BAD_PARAM ||
              status == ST_CAPACITY)) |-> state_total == '0)
    else $error("state total reported on configuration error");

endmodule

bind trigger_state_mixed_radix_decode tsmrd_checker u_tsmrd_checker (.*);

`default_nettype wire

// ===== tb/tsmrd_decode_checker.sv =====
// Checker for the trigger state decoder: register shadow, decode prediction, result compare.
module tsmrd_decode_checker import tsmrd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic [ID_W-1:0]      state_number,
  input  logic                 done,
  input  logic [STAT_W-1:0]    status,
  input  logic [CH_W-1:0]      switch_channel,
  input  logic                 second_switch_select,
  input  logic                 polarity,
  input  logic [ID_W-1:0]      frequency_index,
  input  logic [ID_W-1:0]      waveform_index,
  input  logic [OUT_TOT_W-1:0] state_total,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  input  logic [DATA_W-1:0]    prdata,
  input  logic                 pready,
  output int                   mismatches,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t              status;
    logic [CH_W-1:0]      chan;
    logic                 sel2;
    logic                 pol;
    logic [ID_W-1:0]      freq_pos;
    logic [ID_W-1:0]      wave_pos;
    logic [OUT_TOT_W-1:0] total;
  } decode_t;

  // register shadow
  logic              map_en_q;
  logic [CH_W-1:0]   ch_q;
  logic [MODE_W-1:0] mode_q;
  logic [CNT_W-1:0]  freq_q;
  logic [CNT_W-1:0]  wave_q;

  decode_t expected_decodes[$];

  function automatic decode_t predict_decode(input logic [ID_W-1:0] id);
    decode_t     r;
    int unsigned pc;
    int unsigned tot;
    int unsigned rest;
    r = '0;
    r.status = ST_OK;
    if (!map_en_q) begin
      r.status = ST_NOT_CFG;
    end else if (ch_q == 0 || ch_q > CHANNEL_LIMIT || mode_q == POL_BAD ||
                 freq_q == 0 || wave_q == 0) begin
      r.status = ST_BAD_PARAM;
    end else begin
      pc  = (mode_q == POL_BOTH) ? 2 : 1;
      tot = int'(ch_q) * pc * int'(freq_q) * int'(wave_q);
      if (tot > STATE_LIMIT) begin
        r.status = ST_CAPACITY;
      end else if (int'(id) >= tot) begin
        r.status = ST_RANGE;
        r.total  = OUT_TOT_W'(tot);
      end else begin
        // waveform is the fastest digit, then frequency, polarity, channel
        rest       = id;
        r.wave_pos = ID_W'(rest % wave_q);
        rest       = rest / wave_q;
        r.freq_pos = ID_W'(rest % freq_q);
        rest       = rest / freq_q;
        r.pol      = (mode_q == POL_BOTH) ? rest[0] : mode_q[0];
        r.sel2     = r.pol;
        r.chan     = CH_W'(rest / pc + 1);
        r.total    = OUT_TOT_W'(tot);
      end
    end
    return r;
  endfunction

  function automatic string fmt_decode(input decode_t d);
    return $sformatf("st=%0d ch=%0d sel2=%0b pol=%0b f=%0d w=%0d tot=%0d",
                     d.status, d.chan, d.sel2, d.pol, d.freq_pos, d.wave_pos, d.total);
  endfunction

  task automatic flag(input string msg);
    if (mismatches < 10) $display("mismatch @%0t: %s", $realtime, msg);
    mismatches = mismatches + 1;
  endtask

  always @(posedge clk) begin : watch
    decode_t          got;
    decode_t          want;
    logic [IDX_W-1:0] ridx;
    logic [DATA_W-1:0] rval;
    if (rst) begin
      map_en_q = 1'b0;
      ch_q     = '0;
      mode_q   = '0;
      freq_q   = '0;
      wave_q   = '0;
      expected_decodes.delete();
      mismatches = 0;
    end else begin
      if (done) begin
        got.status   = status_t'(status);
        got.chan     = switch_channel;
        got.sel2     = second_switch_select;
        got.pol      = polarity;
        got.freq_pos = frequency_index;
        got.wave_pos = waveform_index;
        got.total    = state_total;
        if (expected_decodes.size() == 0) begin
          flag({"unexpected result ", fmt_decode(got)});
        end else begin
          want = expected_decodes.pop_front();
          if (got !== want)
            flag({"exp ", fmt_decode(want), " got ", fmt_decode(got)});
        end
      end
      if (start && !busy) expected_decodes.push_back(predict_decode(state_number));
      if (psel && penable && pready) begin
        ridx = paddr[IDX_LO +: IDX_W];
        if (pwrite) begin
          case (ridx)
            REG_MAP_EN:     map_en_q = pwdata[0];
            REG_CH_COUNT:   ch_q     = pwdata[CH_W-1:0];
            REG_POL_MODE:   mode_q   = pwdata[MODE_W-1:0];
            REG_FREQ_COUNT: freq_q   = pwdata[CNT_W-1:0];
            REG_WAVE_COUNT: wave_q   = pwdata[CNT_W-1:0];
            default: ;
          endcase
        end else if (ridx <= REG_WAVE_COUNT) begin
          case (ridx)
            REG_MAP_EN:     rval = DATA_W'(map_en_q);
            REG_CH_COUNT:   rval = DATA_W'(ch_q);
            REG_POL_MODE:   rval = DATA_W'(mode_q);
            REG_FREQ_COUNT: rval = DATA_W'(freq_q);
            default:        rval = DATA_W'(wave_q);
          endcase
          if (prdata !== rval)
            flag($sformatf("read reg %0d exp %0h got %0h", ridx, rval, prdata));
        end
      end
    end
    pending <= expected_decodes.size();
  end

endmodule

// ===== tb/trigger_state_mixed_radix_decode_tb.sv =====
// Testbench top for the trigger state decoder: clock, reset, stimulus and verdict.
module trigger_state_mixed_radix_decode_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tsmrd_pkg::*;

  // cycles with no transaction of any kind before the run is called hung
  localparam int STALL_LIMIT = 500;
  localparam int RAND_ITEMS  = 1000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [ID_W-1:0]   state_number = '0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;

  logic                 busy;
  logic                 done;
  logic [STAT_W-1:0]    status;
  logic [CH_W-1:0]      switch_channel;
  logic                 second_switch_select;
  logic                 polarity;
  logic [ID_W-1:0]      frequency_index;
  logic [ID_W-1:0]      waveform_index;
  logic [OUT_TOT_W-1:0] state_total;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  int mismatches;
  int pending;
  int sender_idle_pct = 0;
  int idle_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  trigger_state_mixed_radix_decode dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .state_number(state_number),
    .done(done), .status(status), .switch_channel(switch_channel),
    .second_switch_select(second_switch_select), .polarity(polarity),
    .frequency_index(frequency_index), .waveform_index(waveform_index),
    .state_total(state_total),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  tsmrd_decode_checker chk (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .state_number(state_number),
    .done(done), .status(status), .switch_channel(switch_channel),
    .second_switch_select(second_switch_select), .polarity(polarity),
    .frequency_index(frequency_index), .waveform_index(waveform_index),
    .state_total(state_total),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .mismatches(mismatches), .pending(pending)
  );

  // Watchdog: any item, result or register transaction resets the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL trigger_state_mixed_radix_decode");
        $finish;
      end
    end
  end

  // Random fill above the register width; the block has to drop it.
  function automatic logic [DATA_W-1:0] with_junk(input int unsigned value, input int width);
    logic [DATA_W-1:0] junk;
    junk = $urandom();
    return (junk << width) | DATA_W'(value);
  endfunction

  // Count drawn toward its extremes.
  function automatic int unsigned pick_count(input int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return hi;
    if (r < 40) return 1;
    return $urandom_range(1, hi);
  endfunction

  // One APB transaction: setup cycle, access cycle, then an idle cycle so psel
  // never sees two assignments in one step. Called and returns right after a rising edge.
  task automatic apb_xfer(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data,
                          input logic wr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'(idx) << IDX_LO;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Drain every result, then program all five registers and read them back.
  task automatic apply_config(input int unsigned map, input int unsigned ch,
                              input int unsigned mode, input int unsigned freq,
                              input int unsigned wave);
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    apb_xfer(REG_MAP_EN,     with_junk(map, 1),       1'b1);
    apb_xfer(REG_CH_COUNT,   with_junk(ch, CH_W),     1'b1);
    apb_xfer(REG_POL_MODE,   with_junk(mode, MODE_W), 1'b1);
    apb_xfer(REG_FREQ_COUNT, with_junk(freq, CNT_W),  1'b1);
    apb_xfer(REG_WAVE_COUNT, with_junk(wave, CNT_W),  1'b1);
    // an address past the register list must not disturb anything
    if ($urandom_range(0, 1))
      apb_xfer(IDX_W'(REG_WAVE_COUNT + 1 + $urandom_range(0, 2)), $urandom(), 1'b1);
    for (int i = REG_MAP_EN; i <= REG_WAVE_COUNT; i++) apb_xfer(IDX_W'(i), '0, 1'b0);
  endtask

  // Present one state number, each cycle in front idle with the given chance,
  // and hold it until the block takes it. busy is sampled at the falling edge.
  task automatic send_item(input int unsigned id);
    logic ok;
    while (sender_idle_pct != 0 && $urandom_range(1, 100) <= sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    state_number <= ID_W'(id);
    do begin
      @(negedge clk);
      ok = !busy;
      @(posedge clk);
    end while (!ok);
  endtask

  initial begin : stim
    int unsigned c_map, c_ch, c_mode, c_freq, c_wave;
    int unsigned pc, budget, tot, r, n, id;
    int          rand_items;
    int          phase;
    rand_items = 0;
    phase      = 0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part ----
    // registers still at reset: not configured
    send_item(0);
    send_item(1023);
    // zero channels, too many channels, bad polarity mode, zero counts
    apply_config(1, 0, 0, 1, 1);
    send_item(5);
    apply_config(1, CHANNEL_LIMIT + 1, 1, 1, 1);
    send_item(0);
    apply_config(1, 63, 2, 1, 1);
    send_item(0);
    apply_config(1, 1, POL_BAD, 1, 1);
    send_item(0);
    apply_config(1, 1, 0, 0, 1);
    send_item(0);
    apply_config(1, 1, 0, 1, 0);
    send_item(0);
    // capacity just exceeded, and far exceeded with every count bit set
    apply_config(1, 1, 0, 1, STATE_LIMIT + 1);
    send_item(0);
    apply_config(1, CHANNEL_LIMIT, POL_BOTH, 2047, 2047);
    send_item(0);
    // total exactly at capacity, fixed polarity 1, widest waveform count
    apply_config(1, 1, 1, 1, 1024);
    send_item(0);
    send_item(1023);
    // widest frequency count, fixed polarity 0
    apply_config(1, 1, 0, 1024, 1);
    send_item(1023);
    send_item(512);
    // all channels, both polarities
    apply_config(1, CHANNEL_LIMIT, POL_BOTH, 4, 8);
    send_item(0);
    send_item(1023);
    send_item(517);
    // last valid state, first state out of range, top of the field
    apply_config(1, 3, POL_BOTH, 5, 7);
    send_item(209);
    send_item(210);
    send_item(1023);
    // mapping switched off over an otherwise valid setup
    apply_config(0, 3, POL_BOTH, 5, 7);
    send_item(4);

    // ---- random part ----
    while (rand_items < RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        // decodable setup: split the state budget between frequency and waveform
        r      = $urandom_range(0, 99);
        c_ch   = (r < 20) ? 1 : (r < 40) ? CHANNEL_LIMIT : $urandom_range(1, CHANNEL_LIMIT);
        c_mode = $urandom_range(0, 2);
        c_map  = 1;
        pc     = (c_mode == POL_BOTH) ? 2 : 1;
        budget = STATE_LIMIT / (c_ch * pc);
        if ($urandom_range(0, 1)) begin
          c_freq = pick_count(budget);
          c_wave = pick_count(budget / c_freq);
        end else begin
          c_wave = pick_count(budget);
          c_freq = pick_count(budget / c_wave);
        end
      end else begin
        // raw fields: mostly bad parameters or overflow, sometimes mapping off
        c_map  = (r < 92) ? 1 : 0;
        c_ch   = $urandom_range(0, 63);
        c_mode = $urandom_range(0, 3);
        c_freq = $urandom_range(0, 2047);
        c_wave = $urandom_range(0, 2047);
      end
      apply_config(c_map, c_ch, c_mode, c_freq, c_wave);

      // state count, used only to aim the state numbers
      tot = 0;
      if (c_map != 0 && c_ch != 0 && c_ch <= CHANNEL_LIMIT && c_mode != POL_BAD &&
          c_freq != 0 && c_wave != 0) begin
        tot = c_ch * ((c_mode == POL_BOTH) ? 2 : 1) * c_freq * c_wave;
        if (tot > STATE_LIMIT) tot = 0;
      end

      // idling phases: none, sender idle 59%, none, sender idle 14%
      case (phase % 4)
        1:       sender_idle_pct = 59;
        3:       sender_idle_pct = 14;
        default: sender_idle_pct = 0;
      endcase

      n = (tot == 0) ? $urandom_range(4, 12) : $urandom_range(10, 50);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (tot == 0)     id = $urandom_range(0, 1023);
        else if (r < 65)  id = $urandom_range(0, tot - 1);
        else if (r < 75)  id = tot - 1;
        else if (r < 80)  id = 0;
        else if (r < 88)  id = (tot < 1024) ? tot : $urandom_range(0, 1023);
        else              id = $urandom_range(0, 1023);
        send_item(id);
        rand_items++;
      end
      phase++;
    end

    // drain, then give a stray late strobe time to show up
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (2 * PIPE_LAT) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS trigger_state_mixed_radix_decode");
    end else begin
      $display("FAIL trigger_state_mixed_radix_decode");
    end
    $finish;
  end

endmodule
